@@ rtl/icb_pkg.sv @@
package icb_pkg;

  localparam int unsigned PALETTE_SIZE = 256;
  localparam int unsigned CHANNEL_BITS = 5;
  localparam int unsigned BLEND_SHIFT  = 8;

  localparam int unsigned IDX_W      = 8;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned COLOR_W    = 3 * LEVEL_W;
  localparam int unsigned FACTOR_W   = 9;
  localparam int unsigned INV_ADDR_W = 15;
  localparam int unsigned APB_AW     = 3;
  localparam int unsigned APB_DW     = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 9'd128;

  typedef enum logic [1:0] {
    CMD_PAL_WR = 2'd0,
    CMD_INV_WR = 2'd1,
    CMD_BLEND  = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_BLEND_FACTOR = 1'b0
  } reg_e;

  typedef struct packed {
    logic             blend;
    logic             inv_wr;
    logic             bypass;
    logic [IDX_W-1:0] idx;
  } ctl_t;

endpackage

@@ rtl/icb_ram.sv @@
module icb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/icb_mix.sv @@
module icb_mix #(
  parameter int unsigned CHANNEL_BITS = icb_pkg::CHANNEL_BITS,
  parameter int unsigned BLEND_SHIFT  = icb_pkg::BLEND_SHIFT
) (
  input  logic                          clk_i,
  input  logic [icb_pkg::COLOR_W-1:0]   color_a_i,
  input  logic [icb_pkg::COLOR_W-1:0]   color_b_i,
  input  logic [icb_pkg::FACTOR_W-1:0]  factor_i,
  output logic [3*CHANNEL_BITS-1:0]     addr_o
);

  localparam int unsigned FW   = BLEND_SHIFT + 1;
  localparam int unsigned PW   = icb_pkg::LEVEL_W + FW;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned FULL = 1 << BLEND_SHIFT;
  localparam int unsigned TOP  = BLEND_SHIFT + icb_pkg::LEVEL_W - 1;

  logic [FW-1:0] f_sat;
  logic [FW-1:0] f_bar;
  logic [PW-1:0] pa_q [3];
  logic [PW-1:0] pb_q [3];

  // weight saturates at full scale
  always_comb begin
    if (32'(factor_i) > FULL) begin
      f_sat = FW'(FULL);
    end else begin
      f_sat = FW'(factor_i);
    end
    f_bar = FW'(FULL) - f_sat;
  end

  for (genvar n = 0; n < 3; n++) begin : g_ch
    logic [SW-1:0] sum;

    always_ff @(posedge clk_i) begin
      pa_q[n] <= PW'(color_a_i[n*icb_pkg::LEVEL_W +: icb_pkg::LEVEL_W]) * PW'(f_bar);
      pb_q[n] <= PW'(color_b_i[n*icb_pkg::LEVEL_W +: icb_pkg::LEVEL_W]) * PW'(f_sat);
    end

    assign sum = SW'(pa_q[n]) + SW'(pb_q[n]);
    assign addr_o[n*CHANNEL_BITS +: CHANNEL_BITS] = sum[TOP -: CHANNEL_BITS];
  end

endmodule

@@ rtl/indexed_color_blend.sv @@
// channel   | signals                                   | dir | handshake
// ----------+-------------------------------------------+-----+---------------------
// command   | cmd_i, first/second_index_i, *_level_i,   | in  | start & !busy
//           | inverse_address_i, inverse_value_i        |     |
// result    | blended_index_o                           | out | valid_o, one cycle
// config    | psel, penable, pwrite, paddr, pwdata      | in  | apb write, no wait
//
// one item is accepted every cycle; busy stays low
// after its item is accepted, a blend result passes in order through the
// registered palette read, multiply and inverse table read
// inverse writes travel the same pipe, so reads and writes keep item order
// reset clears the pipeline valid bits and sets blend_factor to 128; the
// palette and inverse table hold no reset value
// the receiver cannot stall, so nothing backs up
module indexed_color_blend #(
  parameter int unsigned PALETTE_SIZE = icb_pkg::PALETTE_SIZE,
  parameter int unsigned CHANNEL_BITS = icb_pkg::CHANNEL_BITS,
  parameter int unsigned BLEND_SHIFT  = icb_pkg::BLEND_SHIFT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      cmd_i,
  input  logic [icb_pkg::IDX_W-1:0]       first_index_i,
  input  logic [icb_pkg::IDX_W-1:0]       second_index_i,
  input  logic [icb_pkg::LEVEL_W-1:0]     red_level_i,
  input  logic [icb_pkg::LEVEL_W-1:0]     green_level_i,
  input  logic [icb_pkg::LEVEL_W-1:0]     blue_level_i,
  input  logic [icb_pkg::INV_ADDR_W-1:0]  inverse_address_i,
  input  logic [icb_pkg::IDX_W-1:0]       inverse_value_i,
  output logic                            valid_o,
  output logic [icb_pkg::IDX_W-1:0]       blended_index_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [icb_pkg::APB_AW-1:0]      paddr,
  input  logic [icb_pkg::APB_DW-1:0]      pwdata,
  output logic [icb_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned PAL_AW = $clog2(PALETTE_SIZE);
  localparam int unsigned INV_AW = 3 * CHANNEL_BITS;
  localparam int unsigned INV_DEPTH = 1 << INV_AW;
  localparam int unsigned IDX_W = icb_pkg::IDX_W;
  localparam int unsigned COLOR_W = icb_pkg::COLOR_W;

  logic                          accept;
  logic                          cfg_wr;
  logic [icb_pkg::FACTOR_W-1:0]  factor_q;
  logic                          pal_we;

  logic                          s1_blend_q;
  logic                          s1_inv_q;
  logic [IDX_W-1:0]              s1_a_q;
  logic [IDX_W-1:0]              s1_b_q;
  logic                          s1_a_oor_q;
  logic                          s1_b_oor_q;
  logic [INV_AW-1:0]             s1_iaddr_q;
  logic [IDX_W-1:0]              s1_ival_q;
  logic [COLOR_W-1:0]            pal_a_rdata;
  logic [COLOR_W-1:0]            pal_b_rdata;
  logic [COLOR_W-1:0]            color_a;
  logic [COLOR_W-1:0]            color_b;
  icb_pkg::ctl_t                 s1_ctl;

  icb_pkg::ctl_t                 s2_ctl_q;
  logic [INV_AW-1:0]             s2_iaddr_q;
  logic [IDX_W-1:0]              s2_ival_q;
  logic [INV_AW-1:0]             mix_addr;
  logic                          inv_we;

  icb_pkg::ctl_t                 s3_ctl_q;
  logic [IDX_W-1:0]              inv_rdata;

  logic [INV_AW+icb_pkg::INV_ADDR_W-1:0] iaddr_ext;
  logic                          first_ok;
  logic                          second_ok;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == icb_pkg::REG_BLEND_FACTOR);
  assign prdata = (paddr[2] == icb_pkg::REG_BLEND_FACTOR) ?
                  icb_pkg::APB_DW'(factor_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= icb_pkg::FACTOR_RESET;
    end else if (cfg_wr) begin
      factor_q <= pwdata[icb_pkg::FACTOR_W-1:0];
    end
  end

  assign first_ok  = (9'(first_index_i) < 9'(PALETTE_SIZE));
  assign second_ok = (9'(second_index_i) < 9'(PALETTE_SIZE));
  assign pal_we    = accept && (cmd_i == icb_pkg::CMD_PAL_WR) && first_ok;
  assign iaddr_ext = {{INV_AW{1'b0}}, inverse_address_i};

  // palette kept twice so both colors are read in the same cycle
  icb_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_pal_a (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (first_index_i[PAL_AW-1:0]),
    .wdata_i ({blue_level_i, green_level_i, red_level_i}),
    .raddr_i (first_index_i[PAL_AW-1:0]),
    .rdata_o (pal_a_rdata)
  );

  icb_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_pal_b (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (first_index_i[PAL_AW-1:0]),
    .wdata_i ({blue_level_i, green_level_i, red_level_i}),
    .raddr_i (second_index_i[PAL_AW-1:0]),
    .rdata_o (pal_b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_blend_q <= 1'b0;
      s1_inv_q   <= 1'b0;
    end else begin
      s1_blend_q <= accept && (cmd_i == icb_pkg::CMD_BLEND);
      s1_inv_q   <= accept && (cmd_i == icb_pkg::CMD_INV_WR);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_a_q     <= first_index_i;
    s1_b_q     <= second_index_i;
    s1_a_oor_q <= !first_ok;
    s1_b_oor_q <= !second_ok;
    s1_iaddr_q <= iaddr_ext[INV_AW-1:0];
    s1_ival_q  <= inverse_value_i;
  end

  assign color_a = s1_a_oor_q ? '0 : pal_a_rdata;
  assign color_b = s1_b_oor_q ? '0 : pal_b_rdata;

  always_comb begin
    s1_ctl.blend  = s1_blend_q;
    s1_ctl.inv_wr = s1_inv_q;
    if ((s1_a_q == '0) || (s1_a_q == s1_b_q) || (color_a == '0)) begin
      s1_ctl.bypass = 1'b1;
      s1_ctl.idx    = s1_a_q;
    end else if ((s1_b_q == '0) || (color_b == '0)) begin
      s1_ctl.bypass = 1'b1;
      s1_ctl.idx    = s1_b_q;
    end else begin
      s1_ctl.bypass = 1'b0;
      s1_ctl.idx    = s1_a_q;
    end
  end

  icb_mix #(.CHANNEL_BITS(CHANNEL_BITS), .BLEND_SHIFT(BLEND_SHIFT)) u_mix (
    .clk_i     (clk_i),
    .color_a_i (color_a),
    .color_b_i (color_b),
    .factor_i  (factor_q),
    .addr_o    (mix_addr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
      s3_ctl_q <= '0;
    end else begin
      s2_ctl_q <= s1_ctl;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_iaddr_q <= s1_iaddr_q;
    s2_ival_q  <= s1_ival_q;
  end

  assign inv_we = s2_ctl_q.inv_wr;

  icb_ram #(.WIDTH(IDX_W), .DEPTH(INV_DEPTH)) u_inv (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (s2_iaddr_q),
    .wdata_i (s2_ival_q),
    .raddr_i (mix_addr),
    .rdata_o (inv_rdata)
  );

  assign valid_o         = s3_ctl_q.blend;
  assign blended_index_o = s3_ctl_q.bypass ? s3_ctl_q.idx : inv_rdata;

  a_result_from_blend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept && (cmd_i == icb_pkg::CMD_BLEND), 3))
    else $error("result without a blend item");

  a_blend_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i == icb_pkg::CMD_BLEND) |-> ##3 valid_o)
    else $error("blend item lost");

  a_inv_write_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    inv_we |-> $past(accept && (cmd_i == icb_pkg::CMD_INV_WR), 2))
    else $error("inverse write out of order");

  a_factor_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (factor_q == $past(pwdata[icb_pkg::FACTOR_W-1:0])))
    else $error("blend factor not written");

endmodule
